// ----- src/sfs_pkg.sv -----
`default_nettype none
package sfs_pkg;

  // Default sizes
  localparam int MAX_FRAMES_DEF = 64;
  localparam int TIME_BITS_DEF  = 16;

  // Fixed field widths
  localparam int SLOT_W    = 6;
  localparam int DUR_W     = 16;
  localparam int INDEX_W   = 6;
  localparam int FCOUNT_W  = 7;
  localparam int RTIME_W   = 16;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_RESTART = 2'd2
  } req_kind_t;

  // Play modes
  typedef enum logic [1:0] {
    PLAY_LOOP       = 2'd0,
    PLAY_PING_PONG  = 2'd1,
    PLAY_HOLD_LAST  = 2'd2,
    PLAY_BACK_FIRST = 2'd3
  } play_mode_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PLAY_MODE    = 2'd0,
    REG_FRAME_COUNT  = 2'd1,
    REG_RESTART_TIME = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

// ----- src/sfs_ram.sv -----
`default_nettype none
module sfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/sprite_frame_sequencer.sv -----
`default_nettype none
// Animation frame sequencer. Each request on the in_ stream is a tick, a write of one
// frame's duration into the duration table, or a restart; each request gives exactly
// one result (frame index, running, forward) on the out_ stream. One request is taken
// every clock unless the output stage is full: the per-request work is a short compare
// and increment between the state registers and the result register, and a two-entry
// output stage keeps in_tready high while one result waits. The duration table sits in
// a RAM that is read every clock at the address of the frame that will be shown next,
// with a bypass for a write to that same frame, so a tick always sees the current
// frame's duration. The table is not cleared by reset: write the duration of every
// frame that will be shown before ticking. Write the cfg_ registers only while idle.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Request stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [5:0] frame_slot, [21:6] duration, [23:22] zero
  input  wire logic [sfs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  wire logic [1:0]                      in_tuser,
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] frame_index, [6] running, [7] forward
  output logic      [sfs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Configuration port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [sfs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [sfs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int NW  = (CW > sfs_pkg::FCOUNT_W) ? CW : sfs_pkg::FCOUNT_W;
  localparam int EW  = TIME_BITS + 1;
  localparam int RW  = (EW > sfs_pkg::RTIME_W) ? EW : sfs_pkg::RTIME_W;
  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

  // Configuration registers
  logic [1:0]                     play_mode_r;
  logic [sfs_pkg::FCOUNT_W-1:0]   frame_count_r;
  logic [sfs_pkg::RTIME_W-1:0]    restart_time_r;
  logic                           cfg_wr;
  sfs_pkg::reg_idx_t              cfg_idx;

  // Sequencer state
  logic [FW-1:0] frame_r, frame_nxt;
  logic          fwd_r, fwd_nxt;
  logic          run_r, run_nxt;
  logic [EW-1:0] elapsed_r, elapsed_nxt;

  // Duration table access
  logic                 wr_en;
  logic [FW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic [FW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] ram_rdata;
  logic                 byp_hit_r;
  logic [TIME_BITS-1:0] byp_data_r;
  logic [TIME_BITS-1:0] cur_dur;

  // Request fields
  logic                        in_fire;
  logic [1:0]                  in_mode;
  logic [sfs_pkg::SLOT_W-1:0]  in_slot;
  logic [sfs_pkg::DUR_W-1:0]   in_dur;
  logic                        slot_ok;

  // Step logic
  logic [CW-1:0] n_eff;
  logic [NW-1:0] fc_ext;
  logic [FW:0]   f_inc;
  logic [FW-1:0] n_m1, n_m2;
  logic [FW-1:0] adv_frame;
  logic          adv_fwd, adv_run;
  logic [EW-1:0] elapsed_inc;
  logic          dur_over, idle_over;

  // Output stage
  logic                           out_valid_r;
  logic [sfs_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                           skid_valid_r;
  logic [sfs_pkg::OUT_DATA_W-1:0] skid_data_r;
  logic                           out_take;
  logic [sfs_pkg::OUT_DATA_W-1:0] res;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = sfs_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r    <= sfs_pkg::PLAY_LOOP;
      frame_count_r  <= sfs_pkg::FCOUNT_W'(1);
      restart_time_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sfs_pkg::REG_PLAY_MODE:    play_mode_r    <= cfg_pwdata[1:0];
        sfs_pkg::REG_FRAME_COUNT:  frame_count_r  <= cfg_pwdata[sfs_pkg::FCOUNT_W-1:0];
        sfs_pkg::REG_RESTART_TIME: restart_time_r <= cfg_pwdata[sfs_pkg::RTIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sfs_pkg::REG_PLAY_MODE:    cfg_prdata = sfs_pkg::CFG_DATA_W'(play_mode_r);
      sfs_pkg::REG_FRAME_COUNT:  cfg_prdata = sfs_pkg::CFG_DATA_W'(frame_count_r);
      sfs_pkg::REG_RESTART_TIME: cfg_prdata = sfs_pkg::CFG_DATA_W'(restart_time_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Unpack request
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign in_mode   = in_tuser;
  assign in_slot   = in_tdata[5:0];
  assign in_dur    = in_tdata[21:6];
  assign slot_ok   = 32'(in_slot) < 32'(MAX_FRAMES);

  // Clamp frame count to 1..MAX_FRAMES
  assign fc_ext = NW'(frame_count_r);
  always_comb begin
    if (fc_ext == '0) begin
      n_eff = CW'(1);
    end else if (fc_ext > NW'(MAX_FRAMES)) begin
      n_eff = CW'(MAX_FRAMES);
    end else begin
      n_eff = CW'(fc_ext);
    end
  end

  assign n_m1  = FW'(n_eff - CW'(1));
  assign n_m2  = (n_eff >= CW'(2)) ? FW'(n_eff - CW'(2)) : '0;
  assign f_inc = {1'b0, frame_r} + (FW+1)'(1);

  // Next frame on an advance
  always_comb begin
    adv_frame = frame_r;
    adv_fwd   = fwd_r;
    adv_run   = run_r;
    if (fwd_r) begin
      if (f_inc >= (FW+1)'(n_eff)) begin
        case (play_mode_r)
          sfs_pkg::PLAY_LOOP: adv_frame = '0;
          sfs_pkg::PLAY_PING_PONG: begin
            adv_frame = n_m2;
            adv_fwd   = 1'b0;
          end
          sfs_pkg::PLAY_HOLD_LAST: begin
            adv_frame = n_m1;
            adv_run   = 1'b0;
          end
          default: begin
            adv_frame = '0;
            adv_run   = 1'b0;
          end
        endcase
      end else begin
        adv_frame = f_inc[FW-1:0];
      end
    end else if (frame_r == '0) begin
      case (play_mode_r)
        sfs_pkg::PLAY_LOOP: adv_frame = n_m1;
        sfs_pkg::PLAY_PING_PONG: begin
          adv_frame = (n_eff >= CW'(2)) ? FW'(1) : '0;
          adv_fwd   = 1'b1;
        end
        sfs_pkg::PLAY_HOLD_LAST: begin
          adv_frame = '0;
          adv_run   = 1'b0;
        end
        default: begin
          adv_frame = n_m1;
          adv_run   = 1'b0;
        end
      endcase
    end else begin
      adv_frame = frame_r - FW'(1);
      if ((FW+1)'(adv_frame) >= (FW+1)'(n_eff)) begin
        adv_frame = n_m1;
      end
    end
  end

  // Saturating count and thresholds
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + EW'(1);
  assign cur_dur     = byp_hit_r ? byp_data_r : ram_rdata;
  assign dur_over    = elapsed_inc > EW'(cur_dur);
  assign idle_over   = (restart_time_r != '0) && (RW'(elapsed_inc) > RW'(restart_time_r));

  // Apply one request
  always_comb begin
    frame_nxt   = frame_r;
    fwd_nxt     = fwd_r;
    run_nxt     = run_r;
    elapsed_nxt = elapsed_r;
    wr_en       = 1'b0;
    if (in_fire) begin
      case (in_mode)
        sfs_pkg::REQ_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (run_r) begin
            if (dur_over) begin
              elapsed_nxt = '0;
              frame_nxt   = adv_frame;
              fwd_nxt     = adv_fwd;
              run_nxt     = adv_run;
            end
          end else if (idle_over) begin
            frame_nxt = '0;
            fwd_nxt   = 1'b1;
            run_nxt   = 1'b1;
          end
        end
        sfs_pkg::REQ_WRITE: wr_en = slot_ok;
        sfs_pkg::REQ_RESTART: begin
          frame_nxt = '0;
          fwd_nxt   = 1'b1;
          run_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      fwd_r     <= 1'b1;
      run_r     <= 1'b1;
      elapsed_r <= '0;
    end else begin
      frame_r   <= frame_nxt;
      fwd_r     <= fwd_nxt;
      run_r     <= run_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Duration table: read the frame shown next, bypass a same-cycle write to it
  assign wr_addr = FW'(in_slot);
  assign wr_data = TIME_BITS'(in_dur);
  assign rd_addr = rst_n ? frame_nxt : '0;

  sfs_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr_en && (wr_addr == rd_addr);
    end
    byp_data_r <= wr_data;
  end

  // Result and two-entry output stage
  assign res      = {fwd_nxt, run_nxt, sfs_pkg::INDEX_W'(frame_nxt)};
  assign out_take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sfs_pkg::*;

  localparam int MAX_FRAMES  = MAX_FRAMES_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [15:0] dur;
  } request_t;

  typedef struct packed {
    logic [5:0] frame;
    logic       run;
    logic       fwd;
  } view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [5:0] frame_slot, [21:6] duration, [23:22] zero
  logic [1:0]            in_tuser = '0;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [5:0] frame_index, [6] running, [7] forward

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sprite_frame_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Animation state mirror, reset values
  logic [5:0]  anim_frame = '0;
  logic        anim_fwd = 1'b1;
  logic        anim_run = 1'b1;
  logic [16:0] since_advance = '0;
  logic [15:0] frame_time [MAX_FRAMES];
  logic [1:0]  cfg_play = PLAY_LOOP;
  logic [6:0]  cfg_count = 7'd1;
  logic [15:0] cfg_restart = '0;

  request_t send_queue [$];
  view_t    expected_views [$];
  request_t next_req;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  function automatic int strip_length();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_FRAMES) return MAX_FRAMES;
    return cfg_count;
  endfunction

  function automatic void restart_strip();
    anim_frame = '0;
    anim_fwd = 1'b1;
    anim_run = 1'b1;
  endfunction

  // Move one frame in the current direction, folding at the strip ends
  function automatic void step_frame();
    int n;
    int f;
    n = strip_length();
    f = anim_frame;
    if (anim_fwd) begin
      f++;
      if (f >= n) begin
        case (play_mode_t'(cfg_play))
          PLAY_LOOP: f = 0;
          PLAY_PING_PONG: begin
            f = (n >= 2) ? n - 2 : 0;
            anim_fwd = 1'b0;
          end
          PLAY_HOLD_LAST: begin
            f = n - 1;
            anim_run = 1'b0;
          end
          default: begin
            f = 0;
            anim_run = 1'b0;
          end
        endcase
      end
    end else if (f == 0) begin
      case (play_mode_t'(cfg_play))
        PLAY_LOOP: f = n - 1;
        PLAY_PING_PONG: begin
          f = (n >= 2) ? 1 : 0;
          anim_fwd = 1'b1;
        end
        PLAY_HOLD_LAST: begin
          f = 0;
          anim_run = 1'b0;
        end
        default: begin
          f = n - 1;
          anim_run = 1'b0;
        end
      endcase
    end else begin
      f--;
      if (f >= n) f = n - 1;
    end
    anim_frame = f[5:0];
  endfunction

  function automatic void tick_clock();
    if (since_advance != '1) since_advance++;
    if (anim_run) begin
      if (since_advance > {1'b0, frame_time[anim_frame]}) begin
        since_advance = '0;
        step_frame();
      end
    end else if (cfg_restart != 0 && since_advance > {1'b0, cfg_restart}) begin
      restart_strip();
    end
  endfunction

  // Apply one accepted request and queue the frame view it should produce
  function automatic void predict_view(logic [1:0] kind, logic [5:0] slot, logic [15:0] dur);
    case (kind)
      REQ_TICK:    tick_clock();
      REQ_WRITE:   frame_time[slot] = dur;
      REQ_RESTART: restart_strip();
      default: ;
    endcase
    expected_views.push_back('{frame: anim_frame, run: anim_run, fwd: anim_fwd});
  endfunction

  task automatic check_view(logic [OUT_DATA_W-1:0] data);
    view_t want;
    if (expected_views.size() == 0) begin
      $error("result %h with no request outstanding", data);
      fail_count++;
    end else begin
      want = expected_views.pop_front();
      if (data[5:0] !== want.frame) begin
        $error("frame_index: expected %0d, got %0d", want.frame, data[5:0]);
        fail_count++;
      end
      if (data[6] !== want.run) begin
        $error("running: expected %0b, got %0b", want.run, data[6]);
        fail_count++;
      end
      if (data[7] !== want.fwd) begin
        $error("forward: expected %0b, got %0b", want.fwd, data[7]);
        fail_count++;
      end
    end
  endtask

  // Drive the next request when the channel is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        next_req = send_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_req.kind;
        in_tdata <= {2'b00, next_req.dur, next_req.slot};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_view(in_tuser, in_tdata[5:0], in_tdata[21:6]);
      if (out_tvalid && out_tready) check_view(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write a register, mirror it, then read it back
  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    logic [31:0] got;
    logic [31:0] want;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_PLAY_MODE:    cfg_play = value[1:0];
      REG_FRAME_COUNT:  cfg_count = value[6:0];
      REG_RESTART_TIME: cfg_restart = value[15:0];
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_PLAY_MODE:    want = {30'd0, cfg_play};
      REG_FRAME_COUNT:  want = {25'd0, cfg_count};
      default:          want = {16'd0, cfg_restart};
    endcase
    if (got !== want) begin
      $error("register %s: expected %0d, got %0d", idx.name(), want, got);
      fail_count++;
    end
  endtask

  task automatic queue_req(logic [1:0] kind, logic [5:0] slot, logic [15:0] dur);
    send_queue.push_back('{kind: kind, slot: slot, dur: dur});
  endtask

  // Ticks carry junk in the unused fields
  task automatic queue_ticks(int count);
    repeat (count) queue_req(REQ_TICK, 6'($urandom), 16'($urandom));
  endtask

  // Hold until every request is sent and every result is back
  task automatic drain();
    do @(negedge clk);
    while (send_queue.size() != 0 || in_tvalid || expected_views.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(int gap_pct, int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    int d;
    r.slot = 6'($urandom);
    r.dur = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.kind = REQ_TICK;
    end else if (pick < 93) begin
      r.kind = REQ_WRITE;
      if ($urandom_range(0, 3) != 0) r.slot = 6'($urandom_range(0, strip_length() - 1));
      d = $urandom_range(0, 99);
      if (d < 75) r.dur = 16'($urandom_range(0, 3));
      else if (d < 95) r.dur = 16'($urandom_range(4, 15));
    end else if (pick < 97) begin
      r.kind = REQ_RESTART;
    end else begin
      r.kind = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic random_settings();
    int c;
    cfg_write(REG_PLAY_MODE, $urandom_range(0, 3));
    c = $urandom_range(0, 9);
    if (c < 3) cfg_write(REG_FRAME_COUNT, $urandom_range(1, 4));
    else if (c < 4) cfg_write(REG_FRAME_COUNT, $urandom_range(0, 1));
    else if (c < 6) cfg_write(REG_FRAME_COUNT, $urandom_range(64, 127));
    else cfg_write(REG_FRAME_COUNT, $urandom_range(1, 64));
    c = $urandom_range(0, 9);
    if (c == 0) cfg_write(REG_RESTART_TIME, 0);
    else if (c == 1) cfg_write(REG_RESTART_TIME, 16'hFFFF);
    else if (c < 7) cfg_write(REG_RESTART_TIME, $urandom_range(1, 8));
    else cfg_write(REG_RESTART_TIME, $urandom_range(9, 200));
  endtask

  play_mode_t strip_modes [4] = '{PLAY_LOOP, PLAY_PING_PONG, PLAY_HOLD_LAST, PLAY_BACK_FIRST};
  int         gap_plan [4] = '{0, 51, 0, 23};
  int         stall_plan [4] = '{0, 0, 51, 23};

  initial begin
    for (int s = 0; s < MAX_FRAMES; s++) frame_time[s] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the whole duration table before any tick can read it
    for (int s = 0; s < MAX_FRAMES; s++) queue_req(REQ_WRITE, 6'(s), 16'($urandom_range(0, 2)));
    queue_req(REQ_WRITE, 6'd63, 16'hFFFF);
    queue_req(REQ_UNUSED, 6'h3F, 16'hFFFF);
    for (int s = 0; s < 3; s++) queue_req(REQ_WRITE, 6'(s), 16'h0000);
    drain();

    // Walk every play mode over a three-frame strip, through stop and auto restart
    cfg_write(REG_FRAME_COUNT, 3);
    cfg_write(REG_RESTART_TIME, 2);
    foreach (strip_modes[m]) begin
      cfg_write(REG_PLAY_MODE, strip_modes[m]);
      queue_req(REQ_RESTART, 6'h00, 16'h0000);
      queue_ticks(7);
      drain();
    end
    // Out-of-range frame counts
    cfg_write(REG_PLAY_MODE, PLAY_PING_PONG);
    cfg_write(REG_FRAME_COUNT, 0);
    queue_ticks(3);
    drain();
    cfg_write(REG_FRAME_COUNT, 127);
    queue_req(REQ_UNUSED, 6'h00, 16'h0000);
    queue_ticks(3);
    drain();

    // Random traffic under each idling pattern, two settings apiece
    foreach (gap_plan[p]) begin
      repeat (2) begin
        random_settings();
        set_idling(gap_plan[p], stall_plan[p]);
        repeat (68) send_queue.push_back(random_request());
        drain();
      end
    end

    // Stop with no auto restart, idle, then restart without clearing the count
    set_idling(0, 0);
    cfg_write(REG_PLAY_MODE, PLAY_HOLD_LAST);
    cfg_write(REG_FRAME_COUNT, 2);
    cfg_write(REG_RESTART_TIME, 0);
    queue_req(REQ_WRITE, 6'd0, 16'h0000);
    queue_req(REQ_WRITE, 6'd1, 16'h0000);
    queue_req(REQ_RESTART, 6'h00, 16'h0000);
    queue_ticks(14);
    queue_req(REQ_WRITE, 6'd0, 16'd8);
    queue_req(REQ_RESTART, 6'h00, 16'h0000);
    queue_ticks(1);
    drain();

    // Auto restart after a long idle, landing on a frame of maximum duration
    cfg_write(REG_RESTART_TIME, 30);
    queue_req(REQ_WRITE, 6'd0, 16'hFFFF);
    queue_ticks(40);
    drain();

    repeat (8) @(negedge clk);
    if (expected_views.size() != 0) begin
      $error("%0d results never arrived", expected_views.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sfs_pkg.sv
src/sfs_ram.sv
src/sprite_frame_sequencer.sv
tb/sv/tb.sv
